[design/gmlt_pkg.sv]
// Package for the greedy max-level tour unit.
// Holds field widths, parameter defaults and the sequencer state type.
// No dependencies.
package gmlt_pkg;

    localparam int MAX_CITIES_DEF = 32;
    localparam int LEVEL_BITS_DEF = 32;

    localparam int CITY_FW  = 5;
    localparam int LEVEL_FW = 32;
    localparam int COUNT_W  = 6;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;
    localparam logic [6:0]         COUNT_MIN   = 7'd2;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EMIT,
        ST_SCAN,
        ST_DRAIN
    } t_gmlt_state;

endpackage

[design/gmlt_if.sv]
// Request and result channel interfaces of the greedy max-level tour unit.
// Depends on gmlt_pkg for the payload field widths.
interface gmlt_in_if import gmlt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CITY_FW-1:0]  from_city;
    logic [CITY_FW-1:0]  to_city;
    logic [LEVEL_FW-1:0] level;
    logic                start_tour;

    modport source (output valid, from_city, to_city, level, start_tour, input ready);
    modport sink   (input valid, from_city, to_city, level, start_tour, output ready);
endinterface

interface gmlt_out_if import gmlt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CITY_FW-1:0] tour_city;
    logic [CITY_FW-1:0] tour_position;
    logic               last_city;

    modport source (output valid, tour_city, tour_position, last_city, input ready);
    modport sink   (input valid, tour_city, tour_position, last_city, output ready);
endinterface

[design/gmlt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gmlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/greedy_max_level_tour_unit.sv]
// Load: one matrix entry per cycle, ready whenever no tour is being built.
// Tour: city 0 is emitted first after the start request; every further city takes a level-memory
// read per column of the row (ST_SCAN), a drain state for the last read data (ST_DRAIN) and an
// emit state (ST_EMIT), which waits while a result is held unaccepted.
// Reset (synchronous, active low) clears the sequencer, tour state and output valid and
// sets city_count to 32; level memory contents stay undefined until loaded.
module greedy_max_level_tour_unit import gmlt_pkg::*; #(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gmlt_in_if.sink            i_req,
    gmlt_out_if.source         o_res,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata
);

    localparam int CITY_W = $clog2(MAX_CITIES);
    localparam int DEPTH  = MAX_CITIES * MAX_CITIES;
    localparam int ADDR_W = $clog2(DEPTH);

    t_gmlt_state r_state, n_state;

    logic [COUNT_W-1:0]    r_city_count;
    logic [MAX_CITIES-1:0] r_visited;
    logic [CITY_W-1:0]     r_cur;
    logic [CITY_W-1:0]     r_pos;
    logic [CITY_W-1:0]     r_scan;
    logic [CITY_W-1:0]     r_rd_col;
    logic                  r_rd_valid;
    logic                  r_have;
    logic [LEVEL_BITS-1:0] r_best_level;
    logic [CITY_W-1:0]     r_best_city;

    logic                  r_out_valid;
    logic [CITY_FW-1:0]    r_out_city;
    logic [CITY_FW-1:0]    r_out_pos;
    logic                  r_out_last;

    logic                  s_req_ready;
    logic                  s_emit;
    logic                  s_issue;
    logic                  s_accept;
    logic                  s_in_range;
    logic                  s_is_last;
    logic [6:0]            s_count;
    logic [CITY_W-1:0]     s_nm1;
    logic [ADDR_W-1:0]     s_waddr;
    logic [ADDR_W-1:0]     s_raddr;
    logic [LEVEL_BITS-1:0] s_rdata;

    // Clamp the tour length into [2, MAX_CITIES].
    always_comb begin
        s_count = {1'b0, r_city_count};
        if (s_count < COUNT_MIN) begin
            s_count = COUNT_MIN;
        end else if (s_count > 7'(MAX_CITIES)) begin
            s_count = 7'(MAX_CITIES);
        end
    end
    assign s_nm1 = CITY_W'(s_count - 7'd1);

    assign s_accept   = i_req.valid && s_req_ready;
    assign s_in_range = (7'(i_req.from_city) < 7'(MAX_CITIES))
                     && (7'(i_req.to_city) < 7'(MAX_CITIES));
    assign s_waddr    = ADDR_W'(ADDR_W'(CITY_W'(i_req.from_city)) * ADDR_W'(MAX_CITIES)
                               + ADDR_W'(CITY_W'(i_req.to_city)));
    assign s_raddr    = ADDR_W'(ADDR_W'(r_cur) * ADDR_W'(MAX_CITIES) + ADDR_W'(r_scan));
    assign s_is_last  = (r_pos == s_nm1);

    gmlt_ram #(
        .WIDTH (LEVEL_BITS),
        .DEPTH (DEPTH)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (s_accept && s_in_range),
        .i_waddr (s_waddr),
        .i_wdata (LEVEL_BITS'(i_req.level)),
        .i_re    (s_issue),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Sequencer outputs
    always_comb begin
        s_req_ready = (r_state == ST_LOAD);
        s_emit      = (r_state == ST_EMIT) && (!r_out_valid || o_res.ready);
        s_issue     = (r_state == ST_SCAN);
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (s_accept && i_req.start_tour) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (s_emit) begin
                    n_state = s_is_last ? ST_LOAD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan == s_nm1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_city_count <= COUNT_RESET;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_visited    <= '0;
            r_pos        <= '0;
            r_have       <= 1'b0;
            r_cur        <= '0;
            r_best_level <= '0;
            r_best_city  <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= s_issue;

            if (i_cfg_we) begin
                r_city_count <= i_cfg_wdata;
            end

            if (s_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            // Tour starts at city 0 with nothing visited yet.
            if (s_accept && i_req.start_tour) begin
                r_visited   <= '0;
                r_pos       <= '0;
                r_best_city <= '0;
            end

            if (s_emit) begin
                r_out_city           <= CITY_FW'(r_best_city);
                r_out_pos            <= CITY_FW'(r_pos);
                r_out_last           <= s_is_last;
                r_visited[r_best_city] <= 1'b1;
                r_cur                <= r_best_city;
                r_scan               <= '0;
                r_have               <= 1'b0;
                if (!s_is_last) begin
                    r_pos <= r_pos + 1'b1;
                end
            end

            if (s_issue) begin
                r_scan   <= r_scan + 1'b1;
                r_rd_col <= r_scan;
            end

            // First unvisited column seeds the best; later ones must be strictly larger.
            if (r_rd_valid && !r_visited[r_rd_col]) begin
                if (!r_have || (s_rdata > r_best_level)) begin
                    r_best_level <= s_rdata;
                    r_best_city  <= r_rd_col;
                    r_have       <= 1'b1;
                end
            end
        end
    end

    assign i_req.ready         = s_req_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.tour_city     = r_out_city;
    assign o_res.tour_position = r_out_pos;
    assign o_res.last_city     = r_out_last;

    a_rd_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> $past(r_state) == ST_SCAN)
        else $error("level read data without a scan read");

    a_no_revisit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_emit && (r_pos != '0)) |-> !r_visited[r_best_city])
        else $error("tour revisits a city");

    a_visit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> $countones(r_visited) == int'(r_pos))
        else $error("visited set does not match tour position");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_emit && s_is_last) |=> (r_state == ST_LOAD) && r_out_valid && r_out_last)
        else $error("tour did not end after the final city");

endmodule

[tb/sv/greedy_max_level_tour_unit_tb.sv]
// Self-checking testbench for greedy_max_level_tour_unit: loads level matrices,
// starts tours and checks every emitted city against a local greedy tour predictor.
// Depends on gmlt_pkg, the gmlt_in_if/gmlt_out_if interfaces and the unit RTL.
module greedy_max_level_tour_unit_tb;
    import gmlt_pkg::*;

    localparam int NCITY        = MAX_CITIES_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int CFG_SETTLE   = 8;
    localparam int END_DRAIN    = 50;
    localparam int RAND_ITEMS   = 500;
    localparam int MID_FILL     = 256;

    typedef struct packed {
        logic [CITY_FW-1:0]  from_city;
        logic [CITY_FW-1:0]  to_city;
        logic [LEVEL_FW-1:0] level;
        logic                start_tour;
    } t_load_req;

    typedef struct packed {
        logic [CITY_FW-1:0] tour_city;
        logic [CITY_FW-1:0] tour_position;
        logic               last_city;
    } t_tour_stop;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;

    gmlt_in_if  req_if ();
    gmlt_out_if res_if ();

    greedy_max_level_tour_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_load_req           pending_loads [$];
    t_tour_stop          expected_stops [$];
    logic [LEVEL_FW-1:0] level_mem [NCITY][NCITY];
    logic [NCITY-1:0]    loaded_row [NCITY];
    logic [COUNT_W-1:0]  city_count_reg;
    int                  err_cnt;
    int                  pushed_cnt;
    int                  accepted_cnt;
    bit                  idle_on;
    int                  src_gap;
    int                  snk_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("greedy_max_level_tour_unit: mismatch");
        $finish;
    end

    task automatic note_mismatch(string what, int got, int want);
        $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic int clamp_cities(logic [COUNT_W-1:0] cnt);
        if (cnt < COUNT_MIN)
            return COUNT_MIN;
        if (cnt > NCITY)
            return NCITY;
        return cnt;
    endfunction

    // Walk the greedy tour from city 0 and queue every stop.
    function automatic void predict_tour();
        int                  n;
        int                  cur;
        int                  best;
        bit                  have;
        logic [LEVEL_FW-1:0] best_lvl;
        logic [NCITY-1:0]    seen;
        t_tour_stop          stop;
        n    = clamp_cities(city_count_reg);
        cur  = 0;
        seen = '0;
        seen[0] = 1'b1;
        stop.tour_city     = '0;
        stop.tour_position = '0;
        stop.last_city     = (n == 1);
        expected_stops = {expected_stops, stop};
        for (int pos = 1; pos < n; pos++) begin
            have     = 1'b0;
            best     = 0;
            best_lvl = '0;
            for (int c = 0; c < n; c++) begin
                if (!seen[c]) begin
                    // first unvisited city wins when every level is zero
                    if (!have) begin
                        have     = 1'b1;
                        best     = c;
                        best_lvl = '0;
                    end
                    if (level_mem[cur][c] > best_lvl) begin
                        best_lvl = level_mem[cur][c];
                        best     = c;
                    end
                end
            end
            cur        = best;
            seen[best] = 1'b1;
            stop.tour_city     = CITY_FW'(best);
            stop.tour_position = CITY_FW'(pos);
            stop.last_city     = (pos + 1 == n);
            expected_stops = {expected_stops, stop};
        end
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        t_load_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                accepted_cnt++;
                level_mem[req_if.from_city][req_if.to_city] = req_if.level;
                if (req_if.start_tour)
                    predict_tour();
            end
            if (!req_if.valid || req_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_loads.size() > 0) begin
                    nxt = pending_loads.pop_front();
                    req_if.from_city  <= nxt.from_city;
                    req_if.to_city    <= nxt.to_city;
                    req_if.level      <= nxt.level;
                    req_if.start_tour <= nxt.start_tour;
                    req_if.valid      <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 9);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_tour_stop want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_stops.size() == 0) begin
                    note_mismatch("unexpected tour_city", res_if.tour_city, -1);
                end else begin
                    want = expected_stops.pop_front();
                    if (res_if.tour_city !== want.tour_city)
                        note_mismatch("tour_city", res_if.tour_city, want.tour_city);
                    if (res_if.tour_position !== want.tour_position)
                        note_mismatch("tour_position", res_if.tour_position,
                                      want.tour_position);
                    if (res_if.last_city !== want.last_city)
                        note_mismatch("last_city", res_if.last_city, want.last_city);
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                res_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(1, 9) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [LEVEL_FW-1:0] pick_level();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3, 4:    return LEVEL_FW'($urandom_range(1, 3));
            5:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_load(int from_c, int to_c, logic [LEVEL_FW-1:0] lvl, bit start);
        t_load_req r;
        r.from_city  = CITY_FW'(from_c);
        r.to_city    = CITY_FW'(to_c);
        r.level      = lvl;
        r.start_tour = start;
        pending_loads = {pending_loads, r};
        loaded_row[from_c][to_c] = 1'b1;
        pushed_cnt++;
    endtask

    // Load every entry of the n-by-n corner not written yet, so a tour never reads junk.
    task automatic fill_missing(int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!loaded_row[r][c])
                    push_load(r, c, pick_level(), 1'b0);
    endtask

    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || expected_stops.size() > 0)
            @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_city_count(logic [COUNT_W-1:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        city_count_reg = val;
    endtask

    initial begin
        int                 n;
        int                 k;
        int                 directed_cnt;
        logic [COUNT_W-1:0] cfg_val;
        req_if.valid      = 1'b0;
        req_if.from_city  = '0;
        req_if.to_city    = '0;
        req_if.level      = '0;
        req_if.start_tour = 1'b0;
        res_if.ready      = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        i_rst_n           = 1'b0;
        city_count_reg    = COUNT_RESET;
        err_cnt           = 0;
        pushed_cnt        = 0;
        accepted_cnt      = 0;
        idle_on           = 1'b1;
        for (int r = 0; r < NCITY; r++)
            loaded_row[r] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // count below range clamps to two; all-zero row picks lowest unvisited
        write_city_count(6'd0);
        push_load(31, 31, '1, 1'b0);
        push_load(0, 0, '0, 1'b0);
        push_load(1, 0, '0, 1'b0);
        push_load(1, 1, '0, 1'b0);
        push_load(0, 1, '0, 1'b1);

        write_city_count(6'd1);
        push_load(0, 1, '1, 1'b1);

        // tie in row 0, zero row 1, full-scale level in row 2
        write_city_count(6'd4);
        push_load(0, 1, 32'd5, 1'b0);
        push_load(0, 2, 32'd5, 1'b0);
        push_load(0, 3, 32'd3, 1'b0);
        push_load(1, 2, '0, 1'b0);
        push_load(1, 3, '0, 1'b0);
        push_load(2, 3, '1, 1'b0);
        fill_missing(4);
        push_load(3, 3, '0, 1'b1);
        directed_cnt = pushed_cnt;

        while (pushed_cnt < directed_cnt + RAND_ITEMS) begin
            k = $urandom_range(0, 19);
            if (k == 1) begin
                cfg_val = COUNT_W'($urandom_range(0, 1));
            end else if (k == 2 && pushed_cnt + MID_FILL < directed_cnt + RAND_ITEMS) begin
                cfg_val = COUNT_W'($urandom_range(9, 16));
            end else begin
                cfg_val = COUNT_W'($urandom_range(2, 8));
            end
            write_city_count(cfg_val);
            n = clamp_cities(cfg_val);
            // quiet tail: no idling in the last part of the run
            if (pushed_cnt >= directed_cnt + RAND_ITEMS * 4 / 5)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 10)) begin
                    if ($urandom_range(0, 4) == 0)
                        push_load($urandom_range(0, NCITY - 1), $urandom_range(0, NCITY - 1),
                                  pick_level(), 1'b0);
                    else
                        push_load($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                  pick_level(), 1'b0);
                end
                fill_missing(n);
                push_load($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                          pick_level(), 1'b1);
            end
            // leave a partial sequence with no tour start now and then
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4))
                    push_load($urandom_range(0, NCITY - 1), $urandom_range(0, NCITY - 1),
                              pick_level(), 1'b0);
        end

        wait_idle();
        repeat (END_DRAIN) @(posedge i_clk);
        if (expected_stops.size() != 0)
            note_mismatch("stops never emitted", expected_stops.size(), 0);
        if (err_cnt == 0)
            $display("greedy_max_level_tour_unit: match");
        else
            $display("greedy_max_level_tour_unit: mismatch");
        $finish;
    end

endmodule

[sim.f]
design/gmlt_pkg.sv
design/gmlt_if.sv
design/gmlt_ram.sv
design/greedy_max_level_tour_unit.sv
tb/sv/greedy_max_level_tour_unit_tb.sv
